// File: rtl/gdbd_pkg.sv
// Package for the Gregorian days-between-dates block.
// Holds the word types, status codes and calendar tables; depends on nothing.
`default_nettype none

package gdbd_pkg;

  // Field widths fixed by the word layout
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned QUOT_W  = 8;   // year / 100 for any 14-bit year

  // Default legal year window
  localparam int unsigned MIN_YEAR_DEF = 1753;
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Division by 100 as a reciprocal multiply, exact for values below 43699
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_PW    = YEAR_W + 13;

  localparam int unsigned DAYS_PER_YEAR = 365;

  // Month codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    STAT_VALID    = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_REVERSED = 2'd2
  } status_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    status_t            status;
  } out_word_t;

  // One date after the quotient stage
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  prev_year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [QUOT_W-1:0]  year_q100;
    logic [QUOT_W-1:0]  prev_q100;
    logic               range_ok;
  } date_q_t;

  // Days in each month of a common year; zero for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of each month in a common year
  function automatic logic [8:0] month_before(input logic [MONTH_W-1:0] m);
    logic [8:0] days;
    case (m)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gdbd_in_if.sv
// Input channel: valid/ready handshake carrying one pair of dates.
// Depends on gdbd_pkg for the word type.
`default_nettype none

interface gdbd_in_if;
  logic               valid;
  logic               ready;
  gdbd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gdbd_out_if.sv
// Result channel: valid/ready handshake carrying day count and status.
// Depends on gdbd_pkg for the word type.
`default_nettype none

interface gdbd_out_if;
  logic                valid;
  logic                ready;
  gdbd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gregorian_days_between_dates.sv
// Top level: days between two Gregorian dates, with date checks and status.
// Depends on gdbd_pkg, gdbd_in_if and gdbd_out_if.
//
//   channel   | dir | payload                                 | handshake
//   ----------+-----+-----------------------------------------+-----------
//   in_ch     | in  | start/end year, month, day              | valid/ready
//   out_ch    | out | day_count, status                       | valid/ready
//
// Four register stages: input word, quotients by 100, day numbers, result.
// One word is taken per cycle unless out_ch stalls; out_ch.valid is the result valid.
// The depth is set by the constant multiplies per date: the reciprocal divide by 100
// in one stage, the remainder and the day number in the next.
// Each stage advances when it is empty or the next one advances, so a stall
// on out_ch backs up stage by stage and bubbles fill. Reset clears valids only.
`default_nettype none

module gregorian_days_between_dates #(
  parameter int unsigned MIN_YEAR = gdbd_pkg::MIN_YEAR_DEF,
  parameter int unsigned MAX_YEAR = gdbd_pkg::MAX_YEAR_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  gdbd_in_if.sink      in_ch,
  gdbd_out_if.source   out_ch
);
  import gdbd_pkg::*;

  // Stage valids and advance enables
  logic a_v_r, b_v_r, c_v_r, o_v_r;
  logic adv_a, adv_b, adv_c, adv_o;

  // Stage payloads
  date_t              a_date_r [2];
  date_q_t            b_date_nxt [2];
  date_q_t            b_date_r [2];
  logic [COUNT_W-1:0] c_num_nxt [2];
  logic [COUNT_W-1:0] c_num_r [2];
  logic [1:0]         c_ok_nxt;
  logic [1:0]         c_ok_r;
  out_word_t          o_word_nxt;
  out_word_t          o_word_r;

  // Advance a stage when it is empty or the one after it moves
  assign adv_o = !o_v_r || out_ch.ready;
  assign adv_c = !c_v_r || adv_o;
  assign adv_b = !b_v_r || adv_c;
  assign adv_a = !a_v_r || adv_b;

  assign in_ch.ready  = adv_a;
  assign out_ch.valid = o_v_r;
  assign out_ch.data  = o_word_r;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv_a) a_v_r <= in_ch.valid;
      if (adv_b) b_v_r <= a_v_r;
      if (adv_c) c_v_r <= b_v_r;
      if (adv_o) o_v_r <= c_v_r;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_date_r[0] <= '{year: in_ch.data.start_year, month: in_ch.data.start_month,
                       day: in_ch.data.start_day};
      a_date_r[1] <= '{year: in_ch.data.end_year, month: in_ch.data.end_month,
                       day: in_ch.data.end_day};
    end
  end

  // Quotients by 100 of the year and the year before, plus range checks
  always_comb begin
    logic [YEAR_W-1:0]      yr;
    logic [YEAR_W-1:0]      pr;
    logic [DIV100_PW-1:0]   prod_y;
    logic [DIV100_PW-1:0]   prod_p;
    for (int i = 0; i < 2; i++) begin
      yr     = a_date_r[i].year;
      pr     = yr - YEAR_W'(1);
      prod_y = DIV100_PW'(yr) * DIV100_PW'(DIV100_MUL);
      prod_p = DIV100_PW'(pr) * DIV100_PW'(DIV100_MUL);
      b_date_nxt[i].year      = yr;
      b_date_nxt[i].prev_year = pr;
      b_date_nxt[i].month     = a_date_r[i].month;
      b_date_nxt[i].day       = a_date_r[i].day;
      b_date_nxt[i].year_q100 = QUOT_W'(prod_y >> DIV100_SHIFT);
      b_date_nxt[i].prev_q100 = QUOT_W'(prod_p >> DIV100_SHIFT);
      b_date_nxt[i].range_ok  = (32'(yr) >= MIN_YEAR) && (32'(yr) <= MAX_YEAR) &&
                                (a_date_r[i].month >= MONTH_JAN) &&
                                (a_date_r[i].month <= MONTH_DEC);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_date_r <= b_date_nxt;
    end
  end

  // Leap test, day check and day number of each date
  always_comb begin
    logic [YEAR_W-1:0]  rem100;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic [COUNT_W-1:0] n;
    for (int i = 0; i < 2; i++) begin
      rem100 = b_date_r[i].year - YEAR_W'(16'(b_date_r[i].year_q100) * 16'd100);
      leap   = (b_date_r[i].year[1:0] == 2'd0) &&
               ((rem100 != '0) || (b_date_r[i].year_q100[1:0] == 2'd0));
      len    = month_len(b_date_r[i].month) +
               DAY_W'((b_date_r[i].month == MONTH_FEB) && leap);
      c_ok_nxt[i] = b_date_r[i].range_ok && (b_date_r[i].day != '0) &&
                    (b_date_r[i].day <= len);
      n = COUNT_W'(b_date_r[i].prev_year) * COUNT_W'(DAYS_PER_YEAR)
        + COUNT_W'(b_date_r[i].prev_year >> 2)
        - COUNT_W'(b_date_r[i].prev_q100)
        + COUNT_W'(b_date_r[i].prev_q100 >> 2)
        + COUNT_W'(month_before(b_date_r[i].month))
        + COUNT_W'(leap && (b_date_r[i].month > MONTH_FEB))
        + COUNT_W'(b_date_r[i].day);
      c_num_nxt[i] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_num_r <= c_num_nxt;
      c_ok_r  <= c_ok_nxt;
    end
  end

  // Order check and difference; a bad date wins over reversed order
  always_comb begin
    o_word_nxt.day_count = '0;
    if (c_ok_r != 2'b11) begin
      o_word_nxt.status = STAT_BAD_DATE;
    end else if (c_num_r[0] > c_num_r[1]) begin
      o_word_nxt.status = STAT_REVERSED;
    end else begin
      o_word_nxt.status    = STAT_VALID;
      o_word_nxt.day_count = c_num_r[1] - c_num_r[0];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (adv_o) begin
      o_word_r <= o_word_nxt;
    end
  end

endmodule

`default_nettype wire
